// File: rtl/thk_pkg.sv
`timescale 1ns / 1ps

package thk_pkg;

  // Slot count and register map
  localparam int NUM_MAPPINGS_DEF = 4;
  localparam int NUM_MAP_REGS     = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE   = 3'd2;

  localparam logic [15:0] TAP_LIMIT_RST  = 16'd200;
  localparam logic [15:0] DOUBLE_WIN_RST = 16'd300;

  // Mapping register fields
  localparam int MAP_EN_BIT  = 30;
  localparam int MAP_KEY_LSB = 20;
  localparam int MAP_TAP_LSB = 10;
  localparam int MAP_HLD_LSB = 0;
  localparam int KEY_W       = 10;

  // Event codes
  localparam logic [15:0] TYPE_KEY  = 16'd1;
  localparam logic [15:0] TYPE_MISC = 16'd4;
  localparam logic [15:0] CODE_SCAN = 16'd4;
  localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
  localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
  localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

  // Key phases
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_RELEASED = 3'd0;
  localparam logic [PH_W-1:0] PH_PRESSED  = 3'd1;
  localparam logic [PH_W-1:0] PH_TAPPED   = 3'd2;
  localparam logic [PH_W-1:0] PH_DOUBLE   = 3'd3;
  localparam logic [PH_W-1:0] PH_CONSUMED = 3'd4;

  // Time arithmetic: usec / 1000 by reciprocal, exact below 2^20
  localparam logic signed [11:0] MS_PER_SEC  = 12'sd1000;
  localparam int                 RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 21'd1073742;
  localparam int                 RECIP_SHIFT = 30;
  localparam int                 QUOT_W      = 11;
  localparam int                 GAP_W       = 44;

  // Result buffer
  localparam int MAX_RESULTS = 3;
  localparam int RES_IDX_W   = 2;

endpackage

// File: rtl/thk_in_if.sv
`timescale 1ns / 1ps

interface thk_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        ev_type;
  logic [15:0]        ev_code;
  logic signed [31:0] ev_value;
  logic [31:0]        stamp_sec;
  logic [19:0]        stamp_usec;

  modport source (output valid, ev_type, ev_code, ev_value, stamp_sec, stamp_usec,
                  input ready);
  modport sink   (input valid, ev_type, ev_code, ev_value, stamp_sec, stamp_usec,
                  output ready);
endinterface

// File: rtl/thk_out_if.sv
`timescale 1ns / 1ps

interface thk_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_type;
  logic [15:0]        out_code;
  logic signed [31:0] out_value;
  logic [31:0]        out_sec;
  logic [19:0]        out_usec;
  logic               last_of_run;

  modport source (output valid, out_type, out_code, out_value, out_sec, out_usec,
                  last_of_run, input ready);
  modport sink   (input valid, out_type, out_code, out_value, out_sec, out_usec,
                  last_of_run, output ready);
endinterface

// File: rtl/tap_hold_key_remapper.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// in_ch     sink       valid / ready  ev_type, ev_code, ev_value, stamp_sec, stamp_usec
// out_ch    source     valid / ready  out_type, out_code, out_value, out_sec, out_usec,
//                                     last_of_run
// cfg_*     write      cfg_we         cfg_index, cfg_data
//
// An event is registered on transfer and decoded once the result buffer is free, when
// the key state is updated and its results (0 to 3) load the result buffer.
// The result buffer sends one result per cycle while out_ch is ready;
// the next event is decoded in the cycle its predecessor's last result transfers.
// Events with no result (scan, repeat) leave the result buffer empty.
// A stalled out_ch holds the buffer and, once the input register is full, in_ch.
// Reset (rst_n low, synchronous) clears phases, change times, mappings and valid flags.

module tap_hold_key_remapper
  import thk_pkg::*;
#(
  parameter int NUM_MAPPINGS = NUM_MAPPINGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  thk_in_if.sink                in_ch,
  thk_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (NUM_MAPPINGS > 1) ? $clog2(NUM_MAPPINGS) : 1;

  // Configuration registers
  logic [15:0]           tap_lim_r;
  logic [15:0]           dbl_win_r;
  logic [CFG_DATA_W-1:0] map_r [NUM_MAPPINGS];

  // Per-slot key state
  logic [PH_W-1:0] phase_r [NUM_MAPPINGS];
  logic [31:0]     chg_sec_r [NUM_MAPPINGS];
  logic [19:0]     chg_usec_r [NUM_MAPPINGS];

  // Input register
  logic               in_vld_r;
  logic [15:0]        in_type_r;
  logic [15:0]        in_code_r;
  logic signed [31:0] in_value_r;
  logic [31:0]        in_sec_r;
  logic [19:0]        in_usec_r;

  // Result buffer
  logic [RES_IDX_W-1:0] buf_cnt_r;
  logic [RES_IDX_W-1:0] buf_pos_r;
  logic [15:0]          buf_type_r;
  logic [31:0]          buf_sec_r;
  logic [19:0]          buf_usec_r;
  logic [15:0]          buf_code_r [MAX_RESULTS];
  logic signed [31:0]   buf_val_r [MAX_RESULTS];

  logic out_xfer, out_last, buf_free, proc_go;

  assign out_last = (buf_pos_r == buf_cnt_r - 2'd1);
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign buf_free = (buf_cnt_r == '0) || (out_xfer && out_last);
  assign proc_go  = in_vld_r && buf_free;
  assign in_ch.ready = !in_vld_r || buf_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_lim_r <= TAP_LIMIT_RST;
      dbl_win_r <= DOUBLE_WIN_RST;
      for (int i = 0; i < NUM_MAPPINGS; i++) begin
        map_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_TAP_LIMIT) begin
        tap_lim_r <= cfg_data[15:0];
      end
      if (cfg_index == CFG_DOUBLE_WIN) begin
        dbl_win_r <= cfg_data[15:0];
      end
      for (int i = 0; i < NUM_MAPPINGS; i++) begin
        if (i < NUM_MAP_REGS && cfg_index == CFG_MAP_BASE + CFG_IDX_W'(i)) begin
          map_r[i] <= cfg_data;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_type_r  <= in_ch.ev_type;
      in_code_r  <= in_ch.ev_code;
      in_value_r <= in_ch.ev_value;
      in_sec_r   <= in_ch.stamp_sec;
      in_usec_r  <= in_ch.stamp_usec;
    end
  end

  // Event classification
  logic is_scan, is_key, is_rel, is_press, is_rep;
  assign is_scan  = (in_type_r == TYPE_MISC) && (in_code_r == CODE_SCAN);
  assign is_key   = (in_type_r == TYPE_KEY);
  assign is_rel   = (in_value_r == VAL_RELEASE);
  assign is_press = (in_value_r == VAL_PRESS);
  assign is_rep   = (in_value_r == VAL_REPEAT);

  // Slot lookup, lowest index wins
  logic              slot_hit;
  logic [SLOT_W-1:0] slot_idx;
  always_comb begin
    slot_hit = 1'b0;
    slot_idx = '0;
    for (int i = NUM_MAPPINGS - 1; i >= 0; i--) begin
      if (map_r[i][MAP_EN_BIT] &&
          map_r[i][MAP_KEY_LSB +: KEY_W] == in_code_r[KEY_W-1:0] &&
          in_code_r[15:KEY_W] == '0) begin
        slot_hit = 1'b1;
        slot_idx = SLOT_W'(i);
      end
    end
  end

  logic [PH_W-1:0] ph_cur;
  logic [15:0]     tap_code, hold_code;
  assign ph_cur    = phase_r[slot_idx];
  assign tap_code  = 16'(map_r[slot_idx][MAP_TAP_LSB +: KEY_W]);
  assign hold_code = 16'(map_r[slot_idx][MAP_HLD_LSB +: KEY_W]);

  // Millisecond gap to the slot's last change, compared with the active limit
  logic signed [32:0]        ds;
  logic signed [GAP_W-1:0]   ds_ms;
  logic signed [20:0]        du;
  logic [19:0]               du_mag;
  logic [RECIP_SHIFT+QUOT_W-1:0] du_prod;
  logic [QUOT_W-1:0]         du_q;
  logic signed [QUOT_W:0]    du_ms;
  logic signed [GAP_W-1:0]   gap;
  logic signed [GAP_W-1:0]   lim;
  logic                      gap_lt;

  always_comb begin
    ds      = $signed({1'b0, in_sec_r}) - $signed({1'b0, chg_sec_r[slot_idx]});
    ds_ms   = ds * MS_PER_SEC;
    du      = $signed({1'b0, in_usec_r}) - $signed({1'b0, chg_usec_r[slot_idx]});
    du_mag  = du[20] ? 20'(-du) : du[19:0];
    du_prod = (RECIP_SHIFT+QUOT_W)'(du_mag * RECIP_1000);
    du_q    = du_prod[RECIP_SHIFT +: QUOT_W];
    // truncate toward zero
    du_ms   = du[20] ? -$signed({1'b0, du_q}) : $signed({1'b0, du_q});
    gap     = ds_ms + GAP_W'(du_ms);
    lim     = $signed({(GAP_W-16)'(0), (is_press ? dbl_win_r : tap_lim_r)});
    gap_lt  = (gap < lim);
  end

  // Phase transition and result list
  logic [PH_W-1:0]      ph_new;
  logic                 slot_upd;
  logic [RES_IDX_W-1:0] res_n;
  logic [15:0]          res_code [MAX_RESULTS];
  logic signed [31:0]   res_val [MAX_RESULTS];

  always_comb begin
    ph_new   = ph_cur;
    slot_upd = 1'b0;
    res_n    = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res_code[k] = in_code_r;
      res_val[k]  = in_value_r;
    end
    if (is_scan) begin
      res_n = '0;
    end else if (!is_key) begin
      res_n = 2'd1;
    end else if (is_rep) begin
      res_n = '0;
    end else if (!slot_hit) begin
      res_n = 2'd1;
    end else if (is_press) begin
      slot_upd = 1'b1;
      if ((ph_cur == PH_TAPPED || ph_cur == PH_DOUBLE) && gap_lt) begin
        ph_new = PH_DOUBLE;
      end else begin
        ph_new = PH_PRESSED;
      end
      res_n       = 2'd1;
      res_code[0] = (ph_new == PH_DOUBLE) ? tap_code : hold_code;
    end else if (is_rel) begin
      slot_upd = 1'b1;
      if (ph_cur == PH_PRESSED) begin
        ph_new = gap_lt ? PH_TAPPED : PH_RELEASED;
      end else if (ph_cur != PH_TAPPED && ph_cur != PH_DOUBLE) begin
        ph_new = PH_RELEASED;
      end
      case (ph_new)
        PH_TAPPED: begin
          res_n       = 2'd3;
          res_code[0] = hold_code;
          res_val[0]  = VAL_RELEASE;
          res_code[1] = tap_code;
          res_val[1]  = VAL_PRESS;
          res_code[2] = tap_code;
          res_val[2]  = VAL_RELEASE;
        end
        PH_DOUBLE: begin
          res_n       = 2'd1;
          res_code[0] = tap_code;
          res_val[0]  = VAL_RELEASE;
        end
        default: begin
          res_n       = 2'd1;
          res_code[0] = hold_code;
          res_val[0]  = VAL_RELEASE;
        end
      endcase
    end
  end

  // Key state update; a key press consumes every other pressed slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MAPPINGS; i++) begin
        phase_r[i]    <= PH_RELEASED;
        chg_sec_r[i]  <= '0;
        chg_usec_r[i] <= '0;
      end
    end else if (proc_go) begin
      for (int i = 0; i < NUM_MAPPINGS; i++) begin
        if (slot_upd && slot_idx == SLOT_W'(i)) begin
          phase_r[i]    <= ph_new;
          chg_sec_r[i]  <= in_sec_r;
          chg_usec_r[i] <= in_usec_r;
        end else if (is_key && is_press && phase_r[i] == PH_PRESSED) begin
          phase_r[i] <= PH_CONSUMED;
        end
      end
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      buf_pos_r <= '0;
    end else if (proc_go) begin
      buf_cnt_r <= res_n;
      buf_pos_r <= '0;
    end else if (out_xfer) begin
      if (out_last) begin
        buf_cnt_r <= '0;
        buf_pos_r <= '0;
      end else begin
        buf_pos_r <= buf_pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      buf_type_r <= in_type_r;
      buf_sec_r  <= in_sec_r;
      buf_usec_r <= in_usec_r;
      for (int k = 0; k < MAX_RESULTS; k++) begin
        buf_code_r[k] <= res_code[k];
        buf_val_r[k]  <= res_val[k];
      end
    end
  end

  // Result channel
  assign out_ch.valid       = (buf_cnt_r != '0);
  assign out_ch.out_type    = buf_type_r;
  assign out_ch.out_code    = buf_code_r[buf_pos_r];
  assign out_ch.out_value   = buf_val_r[buf_pos_r];
  assign out_ch.out_sec     = buf_sec_r;
  assign out_ch.out_usec    = buf_usec_r;
  assign out_ch.last_of_run = out_last;

endmodule

// File: rtl/thk_checker.sv
`timescale 1ns / 1ps

module thk_checker
  import thk_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        out_type,
  input logic [15:0]        out_code,
  input logic signed [31:0] out_value,
  input logic               last_of_run
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_value)
      && $stable(last_of_run))
    else $error("result changed while stalled");

  // A run that is not finished continues in the next cycle
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("result run broken off");

  // Input back-pressure only while results wait
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  // Multi-result runs come only from key events
  a_run_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_of_run |-> out_type == TYPE_KEY)
    else $error("multi-result run on a non-key event");

endmodule

bind tap_hold_key_remapper thk_checker u_thk_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_type    (out_ch.out_type),
  .out_code    (out_ch.out_code),
  .out_value   (out_ch.out_value),
  .last_of_run (out_ch.last_of_run)
);
